// ===== rtl/assert_macros.svh =====
// Assertion helpers; the SYNTH build drops them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DW_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define DW_ASSERT(lbl, clk, rstn, prop, msg)
`define DW_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// ===== rtl/dwc3s2_pkg.sv =====
package dwc3s2_pkg;

    localparam int DEF_CHANNELS = 256;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [1:0] OP_TAP  = 2'd0;
    localparam logic [1:0] OP_BIAS = 2'd1;
    localparam logic [1:0] OP_ACT  = 2'd2;

    localparam logic REG_IN_ROWS = 1'b0;
    localparam logic REG_IN_COLS = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         tap_index;
        logic [7:0]         channel;
        logic signed [15:0] value;
    } in_item_t;

    typedef struct packed {
        logic [14:0]        out_row;
        logic [4:0]         out_col;
        logic [7:0]         out_channel;
        logic signed [15:0] out_value;
        logic               tensor_done;
    } out_item_t;

    function automatic logic [1:0] inc3(input logic [1:0] m);
        return (m == 2'd2) ? 2'd0 : m + 2'd1;
    endfunction

endpackage

// ===== rtl/depthwise_conv3x3_stride2_top.sv =====
// Depthwise 3x3 stride-2 convolution with zero padding. Takes one item per cycle
// (tap write, bias write or activation in raster order, channel fastest) and
// returns each registered output after the activation that completes its window.
// The line store is six single-write banks (row mod 3 x column parity), odd ones
// dual-read, so all nine window taps and the tap/bias words are read together; the
// current activation is forwarded past its own write. Stalls on m_ready freeze the
// whole pipeline. Stores are undefined until written; no clearing pass is run.
`include "assert_macros.svh"

module depthwise_conv3x3_stride2_top import dwc3s2_pkg::*; #(
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CXW   = (CHW > 8) ? CHW : 8;
    localparam int CIW   = $clog2(MAX_COLS);
    localparam int DEPTH = ((MAX_COLS + 1) / 2) * CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = 36;

    logic [15:0]     in_rows_reg;
    logic [6:0]      in_cols_reg;
    logic [15:0]     row_pos_reg;
    logic [CIW-1:0]  col_pos_reg;
    logic [CHW-1:0]  ch_pos_reg;
    logic [1:0]      row_m3_reg;

    logic signed [15:0] line_even [3][DEPTH];
    logic signed [15:0] line_odd  [3][DEPTH];
    logic signed [15:0] tap_mem   [9][CHANNELS];
    logic signed [15:0] bias_mem  [CHANNELS];

    logic en, acc_in, is_act, tap_ok, ch_ok, last0, row_last, col_last, ch_last;
    logic [15:0]    rows_eff, r_eff;
    logic [31:0]    cols32, addr_a32, addr_b32;
    logic [CIW-1:0] c_eff;
    logic [31:0]    c32, ch32;
    logic [1:0]     m_eff;
    logic [CXW-1:0] chan_x;
    logic [AW-1:0]  addr_a, addr_b;
    logic [8:0]     mask0;
    logic [1:0]     rb0 [3];

    always_comb begin
        en       = !m_valid || m_ready;
        s_ready  = en;
        acc_in   = s_valid && s_ready;
        is_act   = s_item.operation == OP_ACT;
        rows_eff = (in_rows_reg == 16'd0) ? 16'd1 : in_rows_reg;
        if (in_cols_reg == 7'd0) begin
            cols32 = 32'd1;
        end else if (32'(in_cols_reg) > MAX_COLS) begin
            cols32 = 32'(MAX_COLS);
        end else begin
            cols32 = 32'(in_cols_reg);
        end
        r_eff    = (row_pos_reg >= rows_eff) ? 16'd0 : row_pos_reg;
        m_eff    = (row_pos_reg >= rows_eff) ? 2'd0 : row_m3_reg;
        c_eff    = (32'(col_pos_reg) >= cols32) ? '0 : col_pos_reg;
        c32      = 32'(c_eff);
        ch32     = 32'(ch_pos_reg);
        row_last = r_eff == rows_eff - 16'd1;
        col_last = c32 == cols32 - 32'd1;
        ch_last  = ch32 == CHANNELS - 1;
        last0    = row_last && col_last && ch_last;
        chan_x   = CXW'(s_item.channel);
        ch_ok    = 32'(chan_x) < CHANNELS;
        tap_ok   = (s_item.tap_index <= 4'd8) && ch_ok;
        // even bank at h, odd banks at h and h-1 cover every window column
        addr_a32 = (32'(c32 >> 1) * CHANNELS) + ch32;
        addr_b32 = ((c32 >> 1) == 32'd0) ? addr_a32 : addr_a32 - CHANNELS;
        addr_a   = addr_a32[AW-1:0];
        addr_b   = addr_b32[AW-1:0];
        if (r_eff[0]) begin
            rb0[0] = inc3(m_eff);
            rb0[1] = inc3(inc3(m_eff));
            rb0[2] = m_eff;
        end else begin
            rb0[0] = inc3(inc3(m_eff));
            rb0[1] = m_eff;
            rb0[2] = inc3(m_eff);
        end
        for (int dt = 0; dt < 3; dt++) begin
            for (int df = 0; df < 3; df++) begin
                mask0[dt*3+df] = ((dt == 0) ? (r_eff >= 16'd2) : (dt == 2) ? r_eff[0] : 1'b1)
                               && ((df == 0) ? (c32 >= 32'd2) : (df == 2) ? c_eff[0] : 1'b1);
            end
        end
    end

    // configuration and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rows_reg <= 16'd1;
            in_cols_reg <= 7'd64;
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            ch_pos_reg  <= '0;
            row_m3_reg  <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_IN_ROWS: in_rows_reg <= cfg_data;
                    REG_IN_COLS: in_cols_reg <= cfg_data[6:0];
                    default:     ;
                endcase
            end
            if (acc_in && is_act) begin
                if (!ch_last) begin
                    ch_pos_reg  <= CHW'(ch32 + 32'd1);
                    row_pos_reg <= r_eff;
                    col_pos_reg <= c_eff;
                    row_m3_reg  <= m_eff;
                end else begin
                    ch_pos_reg <= '0;
                    if (!col_last) begin
                        col_pos_reg <= c_eff + CIW'(1);
                        row_pos_reg <= r_eff;
                        row_m3_reg  <= m_eff;
                    end else begin
                        col_pos_reg <= '0;
                        row_pos_reg <= row_last ? 16'd0 : r_eff + 16'd1;
                        row_m3_reg  <= row_last ? 2'd0 : inc3(m_eff);
                    end
                end
            end
        end
    end

    // memories: writes on accept, registered reads advance with the pipeline
    logic signed [15:0] rd_ea [3];
    logic signed [15:0] rd_oa [3];
    logic signed [15:0] rd_ob [3];
    logic signed [15:0] tap_rd [9];
    logic signed [15:0] bias_rd;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int b = 0; b < 3; b++) begin
                rd_ea[b] <= line_even[b][addr_a];
                rd_oa[b] <= line_odd[b][addr_a];
                rd_ob[b] <= line_odd[b][addr_b];
            end
        end
        if (acc_in && is_act) begin
            for (int b = 0; b < 3; b++) begin
                if (2'(b) == m_eff) begin
                    if (c_eff[0]) begin
                        line_odd[b][addr_a] <= s_item.value;
                    end else begin
                        line_even[b][addr_a] <= s_item.value;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                tap_rd[k] <= tap_mem[k][ch_pos_reg];
            end
        end
        if (acc_in && s_item.operation == OP_TAP && tap_ok) begin
            for (int k = 0; k < 9; k++) begin
                if (s_item.tap_index == 4'(k)) begin
                    tap_mem[k][chan_x[CHW-1:0]] <= s_item.value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bias_rd <= bias_mem[ch_pos_reg];
        end
        if (acc_in && s_item.operation == OP_BIAS && ch_ok) begin
            bias_mem[chan_x[CHW-1:0]] <= s_item.value;
        end
    end

    // stage 1: window select, forwarding, products
    logic               v1_reg, codd1_reg, last1_reg;
    logic [1:0]         m1_reg;
    logic [1:0]         rb1_reg [3];
    logic [8:0]         mask1_reg;
    logic signed [15:0] cur1_reg;
    logic [14:0]        row1_reg;
    logic [4:0]         col1_reg;
    logic [7:0]         ch1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= acc_in && is_act && (r_eff[0] || row_last) && (c_eff[0] || col_last);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            codd1_reg <= c_eff[0];
            last1_reg <= last0;
            m1_reg    <= m_eff;
            rb1_reg   <= rb0;
            mask1_reg <= mask0;
            cur1_reg  <= s_item.value;
            row1_reg  <= r_eff[15:1];
            col1_reg  <= c32[5:1];
            ch1_reg   <= ch32[7:0];
        end
    end

    logic signed [15:0] ea_f [3];
    logic signed [15:0] oa_f [3];
    logic signed [15:0] win [9];
    logic signed [31:0] prod [9];

    function automatic logic signed [15:0] sel3(input logic [1:0] b,
                                                input logic signed [15:0] x0,
                                                input logic signed [15:0] x1,
                                                input logic signed [15:0] x2);
        unique case (b)
            2'd0:    return x0;
            2'd1:    return x1;
            default: return x2;
        endcase
    endfunction

    always_comb begin
        for (int b = 0; b < 3; b++) begin
            ea_f[b] = (2'(b) == m1_reg && !codd1_reg) ? cur1_reg : rd_ea[b];
            oa_f[b] = (2'(b) == m1_reg && codd1_reg) ? cur1_reg : rd_oa[b];
        end
        for (int dt = 0; dt < 3; dt++) begin
            win[dt*3]   = sel3(rb1_reg[dt], rd_ob[0], rd_ob[1], rd_ob[2]);
            win[dt*3+1] = sel3(rb1_reg[dt], ea_f[0], ea_f[1], ea_f[2]);
            win[dt*3+2] = sel3(rb1_reg[dt], oa_f[0], oa_f[1], oa_f[2]);
        end
        for (int k = 0; k < 9; k++) begin
            prod[k] = mask1_reg[k] ? win[k] * tap_rd[k] : 32'sd0;
        end
    end

    // stage 2: products registered; stage 3: partial sums
    logic               v2_reg, last2_reg, v3_reg, last3_reg;
    logic signed [31:0] prod2_reg [9];
    logic signed [15:0] bias2_reg;
    logic [14:0]        row2_reg, row3_reg;
    logic [4:0]         col2_reg, col3_reg;
    logic [7:0]         ch2_reg, ch3_reg;
    logic signed [SW-1:0] sa3_reg, sb3_reg;
    logic signed [SW-1:0] sa_next, sb_next, acc_sum, rnd;

    always_comb begin
        sa_next = SW'(bias2_reg) <<< 14;
        sb_next = '0;
        for (int k = 0; k < 5; k++) begin
            sa_next = sa_next + SW'(prod2_reg[k]);
        end
        for (int k = 5; k < 9; k++) begin
            sb_next = sb_next + SW'(prod2_reg[k]);
        end
        acc_sum = sa3_reg + sb3_reg;
        rnd     = (acc_sum + SW'(8192)) >>> 14;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            m_valid <= 1'b0;
        end else if (en) begin
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            m_valid <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod2_reg <= prod;
            bias2_reg <= bias_rd;
            last2_reg <= last1_reg;
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
            ch2_reg   <= ch1_reg;
            sa3_reg   <= sa_next;
            sb3_reg   <= sb_next;
            last3_reg <= last2_reg;
            row3_reg  <= row2_reg;
            col3_reg  <= col2_reg;
            ch3_reg   <= ch2_reg;
            m_item.out_row     <= row3_reg;
            m_item.out_col     <= col3_reg;
            m_item.out_channel <= ch3_reg;
            m_item.tensor_done <= last3_reg;
            if (rnd > SW'(32767)) begin
                m_item.out_value <= 16'sh7FFF;
            end else if (rnd < -SW'(32768)) begin
                m_item.out_value <= 16'sh8000;
            end else begin
                m_item.out_value <= rnd[15:0];
            end
        end
    end

    `DW_ASSERT(a_ch_range, aclk, aresetn, 32'(ch_pos_reg) < CHANNELS, "channel position out of range")
    `DW_ASSERT_NEXT(a_stall_hold, aclk, aresetn, v3_reg && !en, v3_reg, "stage lost while stalled")
    `DW_ASSERT_NEXT(a_drain, aclk, aresetn, m_valid && m_ready && !v3_reg, !m_valid, "output repeated")
    `DW_ASSERT_NEXT(a_wrap, aclk, aresetn, acc_in && is_act && last0, row_pos_reg == 16'd0 && col_pos_reg == '0 && ch_pos_reg == '0, "tensor did not wrap")

endmodule

// ===== tb/depthwise_conv3x3_stride2_top_tb.sv =====
module depthwise_conv3x3_stride2_top_tb;
    import dwc3s2_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NCH        = DEF_CHANNELS;
    localparam int          NCOLS      = DEF_MAX_COLS;
    localparam int          NLIVE      = 12;
    localparam logic [1:0]  OP_NONE    = 2'd3;
    localparam int          CYCLE_LIMIT = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    depthwise_conv3x3_stride2_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // conv state mirror
    logic signed [15:0] tap_mem [9*NCH];
    logic signed [15:0] bias_mem [NCH];
    logic signed [15:0] line_mem [3*NCOLS*NCH];
    int          row_pos, col_pos, ch_pos;
    logic [15:0] rows_reg;
    logic [6:0]  cols_reg;

    out_item_t   pending_out[$];
    int          mismatches;
    int          cycles;
    bit          no_gaps;
    int          stall_left;

    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t res;
    } dir_row_t;
    dir_row_t    dir_rows[$];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic int eff_rows();
        return (rows_reg == 0) ? 1 : int'(rows_reg);
    endfunction

    function automatic int eff_cols();
        int c;
        c = (cols_reg == 0) ? 1 : int'(cols_reg);
        return (c > NCOLS) ? NCOLS : c;
    endfunction

    function automatic int lidx(input int r, input int c, input int ch);
        return ((r % 3) * NCOLS + c) * NCH + ch;
    endfunction

    // Updates the mirror; returns 1 with the output when the item completes a window.
    function automatic bit conv_step(input in_item_t it, output out_item_t res);
        int nr, nc, r, c, ch, t2, f2, t, f;
        longint acc, q;
        bit row_ok, col_ok;
        res = '0;
        if (it.operation == OP_TAP) begin
            if (it.tap_index <= 8) tap_mem[it.tap_index * NCH + it.channel] = it.value;
            return 0;
        end
        if (it.operation == OP_BIAS) begin
            bias_mem[it.channel] = it.value;
            return 0;
        end
        if (it.operation != OP_ACT) return 0;
        nr = eff_rows();
        nc = eff_cols();
        if (row_pos >= nr) row_pos = 0;
        if (col_pos >= nc) col_pos = 0;
        r = row_pos; c = col_pos; ch = ch_pos;
        line_mem[lidx(r, c, ch)] = it.value;
        row_ok = (r % 2 == 1) || (r == nr - 1);
        col_ok = (c % 2 == 1) || (c == nc - 1);
        res.tensor_done = (r == nr - 1) && (c == nc - 1) && (ch == NCH - 1);
        ch_pos = ch + 1;
        if (ch_pos >= NCH) begin
            ch_pos = 0;
            col_pos = c + 1;
            if (col_pos >= nc) begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= nr) row_pos = 0;
            end
        end
        if (!(row_ok && col_ok)) return 0;
        t2 = r / 2;
        f2 = c / 2;
        acc = longint'(bias_mem[ch]) * 16384;
        for (int dt = 0; dt < 3; dt++) begin
            t = 2 * t2 - 1 + dt;
            if (t < 0 || t >= nr) continue;
            for (int df = 0; df < 3; df++) begin
                f = 2 * f2 - 1 + df;
                if (f < 0 || f >= nc) continue;
                acc += longint'(line_mem[lidx(t, f, ch)]) *
                       longint'(tap_mem[(dt * 3 + df) * NCH + ch]);
            end
        end
        q = (acc + 8192) >>> 14;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        res.out_row     = t2[14:0];
        res.out_col     = f2[4:0];
        res.out_channel = ch[7:0];
        res.out_value   = q[15:0];
        return 1;
    endfunction

    function automatic logic [15:0] rand_val();
        case ($urandom_range(0, 3))
            0: case ($urandom_range(0, 3))
                   0: return 16'h7fff;
                   1: return 16'h8000;
                   2: return 16'h0000;
                   default: return 16'hffff;
               endcase
            1: return 16'($urandom);
            default: return 16'($urandom_range(0, 2047) - 1024);
        endcase
    endfunction

    function automatic int rand_gap();
        if (no_gaps) return 0;
        if ($urandom_range(0, 99) < 55) return 0;
        if ($urandom_range(0, 99) < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic in_item_t mk(input logic [1:0] op, input logic [3:0] tap,
                                    input logic [7:0] ch, input logic [15:0] val);
        in_item_t it;
        it.operation = op;
        it.tap_index = tap;
        it.channel   = ch;
        it.value     = val;
        return it;
    endfunction

    // Drives one item and records its expected output once accepted.
    task automatic send(input in_item_t it, input bit typed, input out_item_t want);
        int g;
        out_item_t res;
        g = rand_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        if (conv_step(it, res)) pending_out.push_back(typed ? want : res);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_size(input logic [15:0] nr, input logic [15:0] nc);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_IN_ROWS;
        cfg_data  <= nr;
        @(posedge aclk);
        rows_reg = nr;
        cfg_index <= REG_IN_COLS;
        cfg_data  <= nc;
        @(posedge aclk);
        cols_reg = nc[6:0];
        cfg_we <= 1'b0;
    endtask

    // Streams n activations, with coefficient updates and ignored items mixed in.
    task automatic stream_acts(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 2)
                send(mk(OP_TAP, 4'($urandom_range(0, 8)), 8'($urandom), rand_val()), 0, '0);
            else if (k < 3)
                send(mk(OP_BIAS, 4'($urandom), 8'($urandom), rand_val()), 0, '0);
            else if (k < 4)
                send(mk(OP_NONE, 4'($urandom), 8'($urandom), 16'($urandom)), 0, '0);
            else if (k < 5)
                send(mk(OP_TAP, 4'($urandom_range(9, 15)), 8'($urandom), 16'($urandom)),
                     0, '0);
            send(mk(OP_ACT, 4'($urandom), 8'($urandom), rand_val()), 0, '0);
        end
    endtask

    // output side: random stalls and compare against the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_out.size() == 0) begin
                    report("unexpected output, channel", m_item.out_channel, -1);
                end else begin
                    want = pending_out.pop_front();
                    if (m_item.out_row != want.out_row)
                        report("out_row", m_item.out_row, want.out_row);
                    if (m_item.out_col != want.out_col)
                        report("out_col", m_item.out_col, want.out_col);
                    if (m_item.out_channel != want.out_channel)
                        report("out_channel", m_item.out_channel, want.out_channel);
                    if (m_item.out_value !== want.out_value)
                        report("out_value", m_item.out_value, want.out_value);
                    if (m_item.tensor_done !== want.tensor_done)
                        report("tensor_done", m_item.tensor_done, want.tensor_done);
                end
            end
            if (stall_left > 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!no_gaps && $urandom_range(0, 99) < 15) begin
                m_ready    <= 1'b0;
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                          : $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        out_item_t o1, o2;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_IN_ROWS;
        cfg_data  = '0;
        cycles    = 0;
        mismatches = 0;
        no_gaps   = 0;
        row_pos = 0; col_pos = 0; ch_pos = 0;
        rows_reg = 16'd1;
        cols_reg = 7'd64;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero sizes act as a single row and column: every activation emits
        set_size(16'd0, 16'd0);
        for (int c = 0; c < NLIVE; c++) begin
            send(mk(OP_TAP, 4'd4, 8'(c), rand_val()), 0, '0);
            send(mk(OP_TAP, 4'd5, 8'(c), rand_val()), 0, '0);
            send(mk(OP_BIAS, 4'($urandom), 8'(c), rand_val()), 0, '0);
        end
        send(mk(OP_TAP, 4'd4, 8'hff, rand_val()), 0, '0);
        send(mk(OP_TAP, 4'd5, 8'hff, rand_val()), 0, '0);
        send(mk(OP_BIAS, 4'd0, 8'hff, rand_val()), 0, '0);

        o1 = '{out_row: 15'd0, out_col: 5'd0, out_channel: 8'd0,
               out_value: 16'sh7fff, tensor_done: 1'b0};
        o2 = '{out_row: 15'd0, out_col: 5'd0, out_channel: 8'd1,
               out_value: 16'sh8000, tensor_done: 1'b0};
        dir_rows.push_back('{mk(OP_NONE, 4'hf, 8'hff, 16'hffff), 0, '0});
        dir_rows.push_back('{mk(OP_TAP, 4'hf, 8'd0, 16'h1234), 0, '0});
        dir_rows.push_back('{mk(OP_TAP, 4'd4, 8'd0, 16'h4000), 0, '0});
        dir_rows.push_back('{mk(OP_BIAS, 4'd0, 8'd0, 16'h7fff), 0, '0});
        dir_rows.push_back('{mk(OP_ACT, 4'd0, 8'd0, 16'h7fff), 1, o1});
        dir_rows.push_back('{mk(OP_TAP, 4'd4, 8'd1, 16'h4000), 0, '0});
        dir_rows.push_back('{mk(OP_BIAS, 4'd0, 8'd1, 16'h8000), 0, '0});
        dir_rows.push_back('{mk(OP_ACT, 4'd0, 8'd0, 16'h8000), 1, o2});
        dir_rows.push_back('{mk(OP_TAP, 4'd4, 8'd2, 16'h7fff), 0, '0});
        dir_rows.push_back('{mk(OP_TAP, 4'd8, 8'hff, 16'h8000), 0, '0});
        dir_rows.push_back('{mk(OP_BIAS, 4'd0, 8'd2, 16'h0000), 0, '0});
        dir_rows.push_back('{mk(OP_ACT, 4'd0, 8'd0, 16'h0100), 0, '0});
        dir_rows.push_back('{mk(OP_ACT, 4'd0, 8'd0, 16'hffff), 0, '0});
        foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
        stream_acts(NLIVE - ch_pos);

        // row 0 is no longer the last row, so the rest of the sweep stays silent
        set_size(16'd65535, 16'd127);   // clipped to the widest row
        stream_acts(NCH - ch_pos);

        // column 1 of a single row emits over columns 0 and 1
        set_size(16'd1, 16'd2);
        no_gaps = 1;
        stream_acts(NLIVE);
        no_gaps = 0;
        set_size(16'd3, 16'd2);
        stream_acts(NCH - 1 - ch_pos);

        // last channel of the last column closes the tensor
        set_size(16'd1, 16'd2);
        stream_acts(1);

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
